// ===== hw/rtl/npcs_pkg.sv =====
// Shared types and constants for the nearest palette color search core.
// No dependencies.
package npcs_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam int COMP_W = 8;
    localparam int SQ_W   = 16;
    localparam int DIST_W = 18;
    localparam int WORD_W = 32;
    localparam int C15_W  = 15;

    localparam logic [COMP_W-1:0] ALPHA_OPAQUE      = 8'hFF;
    localparam logic [COMP_W-1:0] ALPHA_CLEAR       = 8'h00;
    localparam logic [COMP_W-1:0] TRANSPARENT_INDEX = 8'd255;
    localparam logic [2:0]        EXPAND_ROUND      = 3'b100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } ctrl_state_t;

    typedef struct packed {
        logic accept_write;
        logic accept_lookup;
        logic scan_en;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic out_valid;
    } status_t;

endpackage

// ===== hw/rtl/nearest_palette_color_search_core.sv =====
// Palette write: result registered in the cycle after the item is accepted.
// Lookup: one palette memory read per cycle; one item in flight, next
// accepted on result exit.
// Reset (async, active low) clears control state; palette is undefined
// until written. Top level: ties controller and datapath; uses npcs_pkg.
module nearest_palette_color_search_core
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [npcs_pkg::COMP_W-1:0]     entry_index,
    input  logic [npcs_pkg::COMP_W-1:0]     red,
    input  logic [npcs_pkg::COMP_W-1:0]     green,
    input  logic [npcs_pkg::COMP_W-1:0]     blue,
    input  logic [npcs_pkg::C15_W-1:0]      color15,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            kind,
    output logic [npcs_pkg::WORD_W-1:0]     packed_entry,
    output logic [npcs_pkg::COMP_W-1:0]     nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]     best_distance
);

    npcs_pkg::cmd_t    cmd;
    npcs_pkg::status_t status;

    npcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    npcs_dp
    #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .color15       (color15),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .packed_entry  (packed_entry),
        .nearest_index (nearest_index),
        .best_distance (best_distance)
    );

endmodule

// ===== hw/rtl/npcs_ctrl.sv =====
// Controller state machine: accepts items, sequences the palette scan.
// Depends on npcs_pkg.
module npcs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic               out_ready,
    input  npcs_pkg::status_t  status,
    output npcs_pkg::cmd_t     cmd
);

    npcs_pkg::ctrl_state_t state_reg;
    npcs_pkg::ctrl_state_t state_next;
    logic                  out_free;
    logic                  accept;

    assign out_free = !status.out_valid || out_ready;
    assign in_ready = (state_reg == npcs_pkg::ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= npcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            npcs_pkg::ST_IDLE:
            begin
                if (accept && (op == npcs_pkg::OP_LOOKUP))
                begin
                    state_next = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = npcs_pkg::ST_DRAIN;
                end
            end
            npcs_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy && out_free)
                begin
                    state_next = npcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            npcs_pkg::ST_IDLE:
            begin
                cmd.accept_write  = accept && (op == npcs_pkg::OP_WRITE);
                cmd.accept_lookup = accept && (op == npcs_pkg::OP_LOOKUP);
            end
            npcs_pkg::ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
            end
            npcs_pkg::ST_DRAIN:
            begin
                cmd.load_result = !status.pipe_busy && out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/npcs_dp.sv =====
// Datapath: palette memory, scan address counter, distance pipeline,
// running minimum and output register. Depends on npcs_pkg.
module npcs_dp
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  npcs_pkg::cmd_t                      cmd,
    output npcs_pkg::status_t                   status,
    input  logic [npcs_pkg::COMP_W-1:0]         entry_index,
    input  logic [npcs_pkg::COMP_W-1:0]         red,
    input  logic [npcs_pkg::COMP_W-1:0]         green,
    input  logic [npcs_pkg::COMP_W-1:0]         blue,
    input  logic [npcs_pkg::C15_W-1:0]          color15,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                kind,
    output logic [npcs_pkg::WORD_W-1:0]         packed_entry,
    output logic [npcs_pkg::COMP_W-1:0]         nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]         best_distance
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW     = npcs_pkg::COMP_W;
    localparam int SW     = npcs_pkg::SQ_W;
    localparam int DW     = npcs_pkg::DIST_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

    logic [3*CW-1:0] mem [PALETTE_ENTRIES];

    logic              in_range;
    logic [ADDR_W-1:0] cnt_reg;
    logic [3*CW-1:0]   rd_data_reg;
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic [SW-1:0]     sq_r_reg;
    logic [SW-1:0]     sq_g_reg;
    logic [SW-1:0]     sq_b_reg;
    logic              s2_valid_reg;
    logic [ADDR_W-1:0] s2_idx_reg;
    logic [CW-1:0]     ref_r_reg;
    logic [CW-1:0]     ref_g_reg;
    logic [CW-1:0]     ref_b_reg;
    logic [DW-1:0]     best_dist_reg;
    logic [ADDR_W-1:0] best_idx_reg;
    logic [CW-1:0]     diff_r;
    logic [CW-1:0]     diff_g;
    logic [CW-1:0]     diff_b;
    logic [DW-1:0]     dist_sum;
    logic              take;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [npcs_pkg::WORD_W-1:0] packed_reg;
    logic [CW-1:0]     near_idx_reg;
    logic [DW-1:0]     out_dist_reg;
    logic [CW-1:0]     alpha;

    assign in_range = ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (cmd.accept_write && in_range)
        begin
            mem[entry_index[ADDR_W-1:0]] <= {blue, green, red};
        end
        rd_data_reg <= mem[cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept_lookup)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            s1_valid_reg <= cmd.scan_en;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_lookup)
        begin
            ref_r_reg <= {color15[4:0], npcs_pkg::EXPAND_ROUND};
            ref_g_reg <= {color15[9:5], npcs_pkg::EXPAND_ROUND};
            ref_b_reg <= {color15[14:10], npcs_pkg::EXPAND_ROUND};
        end
        s1_idx_reg <= cnt_reg;
        s2_idx_reg <= s1_idx_reg;
    end

    // stage 1: absolute differences and squares
    assign diff_r = (ref_r_reg > rd_data_reg[CW-1:0])
                  ? ref_r_reg - rd_data_reg[CW-1:0]
                  : rd_data_reg[CW-1:0] - ref_r_reg;
    assign diff_g = (ref_g_reg > rd_data_reg[2*CW-1:CW])
                  ? ref_g_reg - rd_data_reg[2*CW-1:CW]
                  : rd_data_reg[2*CW-1:CW] - ref_g_reg;
    assign diff_b = (ref_b_reg > rd_data_reg[3*CW-1:2*CW])
                  ? ref_b_reg - rd_data_reg[3*CW-1:2*CW]
                  : rd_data_reg[3*CW-1:2*CW] - ref_b_reg;

    always_ff @(posedge clk)
    begin
        sq_r_reg <= SW'(diff_r) * SW'(diff_r);
        sq_g_reg <= SW'(diff_g) * SW'(diff_g);
        sq_b_reg <= SW'(diff_b) * SW'(diff_b);
    end

    // stage 2: sum and running minimum, first entry taken unconditionally
    assign dist_sum = DW'(sq_r_reg) + DW'(sq_g_reg) + DW'(sq_b_reg);
    assign take     = s2_valid_reg
                   && ((s2_idx_reg == '0) || (dist_sum < best_dist_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= s2_idx_reg;
        end
    end

    assign alpha = (entry_index == npcs_pkg::TRANSPARENT_INDEX)
                 ? npcs_pkg::ALPHA_CLEAR : npcs_pkg::ALPHA_OPAQUE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.accept_write || cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_write)
        begin
            kind_reg     <= npcs_pkg::KIND_WRITE;
            packed_reg   <= {alpha, blue, green, red};
            near_idx_reg <= '0;
            out_dist_reg <= '0;
        end
        else if (cmd.load_result)
        begin
            kind_reg     <= npcs_pkg::KIND_LOOKUP;
            packed_reg   <= '0;
            near_idx_reg <= CW'(best_idx_reg);
            out_dist_reg <= best_dist_reg;
        end
    end

    assign status.scan_last = (cnt_reg == LAST_ADDR);
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign status.out_valid = out_valid_reg;

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign packed_entry  = packed_reg;
    assign nearest_index = near_idx_reg;
    assign best_distance = out_dist_reg;

endmodule
